FILE: hdl/ascon128a_aead_engine_unit_assert.svh
// assertion macros for the ascon-128a engine
`ifndef ASCON128A_AEAD_ENGINE_UNIT_ASSERT_SVH
`define ASCON128A_AEAD_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ASC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASC_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASC_ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASC_ASSERT(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/asc_pkg.sv
// shared types, constants and round function of the ascon-128a engine
`timescale 1ns / 1ps
`default_nettype none
package asc_pkg;

   localparam logic [63:0] AEAD_IV = 64'h80800c0800000000;

   typedef logic [0:4][63:0] sponge_type;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_ASSOC = 2'd1,
      ACT_TEXT  = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ASSOC = 2'd1,
      PH_TEXT  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      REG_KEY_HIGH  = 2'd0,
      REG_KEY_LOW   = 2'd1,
      REG_TAG_BYTES = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_INIT, OP_ROUND, OP_KEYTAIL, OP_ADFULL, OP_ADPAD,
      OP_SEP, OP_TEXT, OP_FIN, OP_FINTAIL
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_RND, S_KEYTAIL, S_ADFULL, S_ADPAD, S_SEP,
      S_TEXTS, S_FINS, S_FINTAIL
   } fsm_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] rnd;
      logic       capture;
      logic       pad_zero;
      logic       decrypting;
   } cmd_type;

   function automatic logic [63:0] rotr(logic [63:0] v, int n);
      rotr = (v >> n) | (v << (64 - n));
   endfunction

   function automatic logic [7:0] round_const(logic [3:0] r);
      case (r)
         4'd0:  round_const = 8'hf0;
         4'd1:  round_const = 8'he1;
         4'd2:  round_const = 8'hd2;
         4'd3:  round_const = 8'hc3;
         4'd4:  round_const = 8'hb4;
         4'd5:  round_const = 8'ha5;
         4'd6:  round_const = 8'h96;
         4'd7:  round_const = 8'h87;
         4'd8:  round_const = 8'h78;
         4'd9:  round_const = 8'h69;
         4'd10: round_const = 8'h5a;
         4'd11: round_const = 8'h4b;
         default: round_const = 8'h00;
      endcase
   endfunction

   function automatic sponge_type asc_round(sponge_type s, logic [7:0] rc);
      logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
      x0 = s[0]; x1 = s[1]; x2 = s[2] ^ {56'd0, rc}; x3 = s[3]; x4 = s[4];
      x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
      x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
      asc_round[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
      asc_round[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
      asc_round[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
      asc_round[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
      asc_round[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
   endfunction

   // first n bytes of a big-endian word, n of 8 or more gives all
   function automatic logic [63:0] lead_mask(logic [3:0] n);
      if (n >= 4'd8) lead_mask = '1;
      else lead_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {n[2:0], 3'b000});
   endfunction

   function automatic logic [63:0] pad_at(logic [2:0] n);
      pad_at = 64'h8000_0000_0000_0000 >> {n, 3'b000};
   endfunction

endpackage
`default_nettype wire

FILE: hdl/asc_dp.sv
// sponge state, round unit and result register of the ascon-128a engine
`timescale 1ns / 1ps
`default_nettype none
module asc_dp (
   input  wire logic          clock,
   input  wire asc_pkg::cmd_type cmd,
   input  wire logic [63:0]   key_high,
   input  wire logic [63:0]   key_low,
   input  wire logic [4:0]    tag_bytes,
   input  wire logic [63:0]   req_data_high,
   input  wire logic [63:0]   req_data_low,
   input  wire logic [4:0]    req_byte_count,
   input  wire logic [63:0]   req_check_tag_high,
   input  wire logic [63:0]   req_check_tag_low,
   output logic [63:0]        rsp_text_high,
   output logic [63:0]        rsp_text_low,
   output logic [4:0]         rsp_text_bytes,
   output logic [63:0]        rsp_tag_high,
   output logic [63:0]        rsp_tag_low,
   output logic               rsp_tag_ok,
   output logic               rsp_is_final
);
   asc_pkg::sponge_type x_ff, x_in;
   logic [63:0] hi_ff, lo_ff, chk_hi_ff, chk_lo_ff;
   logic [4:0]  n_ff;
   logic [63:0] th_ff, th_in, tl_ff, tl_in, oh_ff, oh_in, ol_ff, ol_in;
   logic [4:0]  ob_ff, ob_in;
   logic        ok_ff, ok_in, fin_ff, fin_in;

   logic [3:0]  nsel, nf, tsel;
   logic [2:0]  m;
   logic [63:0] mk, c, thm, tlm, t3, t4;

   always_comb begin
      x_in = x_ff;
      oh_in = oh_ff; ol_in = ol_ff; ob_in = ob_ff;
      th_in = th_ff; tl_in = tl_ff; ok_in = ok_ff; fin_in = fin_ff;
      nsel = cmd.pad_zero ? 4'd0 : n_ff[3:0];
      nf = (n_ff > 5'd15) ? 4'd15 : n_ff[3:0];
      m = nf[2:0];
      mk = '0; c = '0;
      // tag length clamped to 1..16
      if (tag_bytes == 5'd0) tsel = 4'd1;
      else if (tag_bytes >= 5'd16) tsel = 4'd0;
      else tsel = tag_bytes[3:0];
      thm = (tsel == 4'd0 || tsel >= 4'd8) ? '1 : asc_pkg::lead_mask(tsel);
      tlm = (tsel == 4'd0) ? '1 :
            (tsel > 4'd8) ? asc_pkg::lead_mask({1'b0, tsel[2:0]}) : '0;
      t3 = x_ff[3] ^ key_high;
      t4 = x_ff[4] ^ key_low;
      unique case (cmd.op)
         asc_pkg::OP_INIT: begin
            x_in[0] = asc_pkg::AEAD_IV; x_in[1] = key_high; x_in[2] = key_low;
            x_in[3] = hi_ff; x_in[4] = lo_ff;
         end
         asc_pkg::OP_ROUND: x_in = asc_pkg::asc_round(x_ff, asc_pkg::round_const(cmd.rnd));
         asc_pkg::OP_KEYTAIL: begin
            x_in[3] = t3; x_in[4] = t4;
         end
         asc_pkg::OP_ADFULL: begin
            x_in[0] = x_ff[0] ^ hi_ff; x_in[1] = x_ff[1] ^ lo_ff;
         end
         asc_pkg::OP_ADPAD: begin
            if (nsel >= 4'd8) begin
               x_in[0] = x_ff[0] ^ hi_ff;
               x_in[1] = x_ff[1] ^ (lo_ff & asc_pkg::lead_mask({1'b0, nsel[2:0]}))
                         ^ asc_pkg::pad_at(nsel[2:0]);
            end else begin
               x_in[0] = x_ff[0] ^ (hi_ff & asc_pkg::lead_mask(nsel))
                         ^ asc_pkg::pad_at(nsel[2:0]);
            end
         end
         asc_pkg::OP_SEP: x_in[4] = x_ff[4] ^ 64'd1;
         asc_pkg::OP_TEXT: begin
            if (cmd.decrypting) begin
               oh_in = x_ff[0] ^ hi_ff; ol_in = x_ff[1] ^ lo_ff;
               x_in[0] = hi_ff; x_in[1] = lo_ff;
            end else begin
               oh_in = x_ff[0] ^ hi_ff; ol_in = x_ff[1] ^ lo_ff;
               x_in[0] = oh_in; x_in[1] = ol_in;
            end
            ob_in = 5'd16; th_in = '0; tl_in = '0; ok_in = 1'b0; fin_in = 1'b0;
         end
         asc_pkg::OP_FIN: begin
            if (nf >= 4'd8) begin
               mk = asc_pkg::lead_mask({1'b0, m});
               c = lo_ff & mk;
               oh_in = x_ff[0] ^ hi_ff;
               if (cmd.decrypting) begin
                  ol_in = (x_ff[1] ^ c) & mk;
                  x_in[0] = hi_ff;
                  x_in[1] = ((x_ff[1] & ~mk) | c) ^ asc_pkg::pad_at(m);
               end else begin
                  x_in[0] = oh_in;
                  x_in[1] = x_ff[1] ^ c ^ asc_pkg::pad_at(m);
                  ol_in = x_in[1] & mk;
               end
            end else begin
               mk = asc_pkg::lead_mask(nf);
               c = hi_ff & mk;
               ol_in = '0;
               if (cmd.decrypting) begin
                  oh_in = (x_ff[0] ^ c) & mk;
                  x_in[0] = ((x_ff[0] & ~mk) | c) ^ asc_pkg::pad_at(m);
               end else begin
                  x_in[0] = x_ff[0] ^ c ^ asc_pkg::pad_at(m);
                  oh_in = x_in[0] & mk;
               end
            end
            ob_in = {1'b0, nf};
            x_in[2] = x_ff[2] ^ key_high;
            x_in[3] = x_ff[3] ^ key_low;
         end
         asc_pkg::OP_FINTAIL: begin
            th_in = t3 & thm;
            tl_in = t4 & tlm;
            ok_in = cmd.decrypting && (th_in == (chk_hi_ff & thm))
                    && (tl_in == (chk_lo_ff & tlm));
            fin_in = 1'b1;
            x_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      oh_ff <= oh_in; ol_ff <= ol_in; ob_ff <= ob_in;
      th_ff <= th_in; tl_ff <= tl_in; ok_ff <= ok_in; fin_ff <= fin_in;
      if (cmd.capture) begin
         hi_ff <= req_data_high;
         lo_ff <= req_data_low;
         n_ff <= req_byte_count;
         chk_hi_ff <= req_check_tag_high;
         chk_lo_ff <= req_check_tag_low;
      end
   end

   assign rsp_text_high = oh_ff;
   assign rsp_text_low = ol_ff;
   assign rsp_text_bytes = ob_ff;
   assign rsp_tag_high = th_ff;
   assign rsp_tag_low = tl_ff;
   assign rsp_tag_ok = ok_ff;
   assign rsp_is_final = fin_ff;
endmodule
`default_nettype wire

FILE: hdl/asc_ctrl.sv
// message sequencer of the ascon-128a engine
`timescale 1ns / 1ps
`default_nettype none
`include "ascon128a_aead_engine_unit_assert.svh"
module asc_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_decrypt,
   input  wire logic [4:0]  req_byte_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output asc_pkg::cmd_type cmd
);
   asc_pkg::fsm_type    state_ff, state_in, ret_ff, ret_in;
   asc_pkg::phase_type  phase_ff, phase_in;
   asc_pkg::action_type act_ff, act_in;
   logic [3:0] rnd_ff, rnd_in;
   logic seen_ff, seen_in, dec_ff, dec_in, padz_ff, padz_in, valid_ff, valid_in;
   logic out_free, emit;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asc_pkg::S_IDLE;
         ret_ff <= asc_pkg::S_IDLE;
         phase_ff <= asc_pkg::PH_IDLE;
         act_ff <= asc_pkg::ACT_START;
         rnd_ff <= '0;
         seen_ff <= 1'b0;
         dec_ff <= 1'b0;
         padz_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         phase_ff <= phase_in;
         act_ff <= act_in;
         rnd_ff <= rnd_in;
         seen_ff <= seen_in;
         dec_ff <= dec_in;
         padz_ff <= padz_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; phase_in = phase_ff; act_in = act_ff;
      rnd_in = rnd_ff; seen_in = seen_ff; dec_in = dec_ff; padz_in = padz_ff;
      emit = 1'b0;
      cmd.op = asc_pkg::OP_NONE;
      cmd.rnd = rnd_ff;
      cmd.capture = 1'b0;
      cmd.pad_zero = padz_ff;
      cmd.decrypting = dec_ff;
      unique case (state_ff)
         asc_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               act_in = asc_pkg::action_type'(req_action);
               padz_in = 1'b0;
               if (asc_pkg::action_type'(req_action) == asc_pkg::ACT_START) begin
                  state_in = asc_pkg::S_INIT;
                  phase_in = asc_pkg::PH_ASSOC;
                  seen_in = 1'b0;
                  dec_in = req_decrypt;
               end else if (phase_ff == asc_pkg::PH_IDLE) begin
                  state_in = asc_pkg::S_IDLE;
               end else if (asc_pkg::action_type'(req_action) == asc_pkg::ACT_ASSOC) begin
                  if (phase_ff != asc_pkg::PH_ASSOC) state_in = asc_pkg::S_IDLE;
                  else if (req_byte_count >= 5'd16) state_in = asc_pkg::S_ADFULL;
                  else if (seen_ff || req_byte_count != 5'd0) state_in = asc_pkg::S_ADPAD;
                  else state_in = asc_pkg::S_SEP;
               end else if (phase_ff == asc_pkg::PH_ASSOC) begin
                  // close associated data, with an empty padded block if any was absorbed
                  padz_in = 1'b1;
                  state_in = seen_ff ? asc_pkg::S_ADPAD : asc_pkg::S_SEP;
               end else if (asc_pkg::action_type'(req_action) == asc_pkg::ACT_TEXT) begin
                  state_in = asc_pkg::S_TEXTS;
               end else begin
                  state_in = asc_pkg::S_FINS;
               end
            end
         end
         asc_pkg::S_INIT: begin
            cmd.op = asc_pkg::OP_INIT;
            rnd_in = 4'd0; ret_in = asc_pkg::S_KEYTAIL; state_in = asc_pkg::S_RND;
         end
         asc_pkg::S_RND: begin
            cmd.op = asc_pkg::OP_ROUND;
            if (rnd_ff == 4'd11) state_in = ret_ff;
            else rnd_in = rnd_ff + 4'd1;
         end
         asc_pkg::S_KEYTAIL: begin
            cmd.op = asc_pkg::OP_KEYTAIL;
            state_in = asc_pkg::S_IDLE;
         end
         asc_pkg::S_ADFULL: begin
            cmd.op = asc_pkg::OP_ADFULL;
            seen_in = 1'b1;
            rnd_in = 4'd4; ret_in = asc_pkg::S_IDLE; state_in = asc_pkg::S_RND;
         end
         asc_pkg::S_ADPAD: begin
            cmd.op = asc_pkg::OP_ADPAD;
            rnd_in = 4'd4; ret_in = asc_pkg::S_SEP; state_in = asc_pkg::S_RND;
         end
         asc_pkg::S_SEP: begin
            cmd.op = asc_pkg::OP_SEP;
            phase_in = asc_pkg::PH_TEXT;
            if (act_ff == asc_pkg::ACT_TEXT) state_in = asc_pkg::S_TEXTS;
            else if (act_ff == asc_pkg::ACT_FINISH) state_in = asc_pkg::S_FINS;
            else state_in = asc_pkg::S_IDLE;
         end
         asc_pkg::S_TEXTS: begin
            if (out_free) begin
               cmd.op = asc_pkg::OP_TEXT;
               emit = 1'b1;
               rnd_in = 4'd4; ret_in = asc_pkg::S_IDLE; state_in = asc_pkg::S_RND;
            end
         end
         asc_pkg::S_FINS: begin
            if (out_free) begin
               cmd.op = asc_pkg::OP_FIN;
               rnd_in = 4'd0; ret_in = asc_pkg::S_FINTAIL; state_in = asc_pkg::S_RND;
            end
         end
         asc_pkg::S_FINTAIL: begin
            cmd.op = asc_pkg::OP_FINTAIL;
            emit = 1'b1;
            phase_in = asc_pkg::PH_IDLE; seen_in = 1'b0; dec_in = 1'b0;
            state_in = asc_pkg::S_IDLE;
         end
         default: state_in = asc_pkg::S_IDLE;
      endcase
      valid_in = emit || (valid_ff && rsp_stall);
   end

   assign req_stall = (state_ff != asc_pkg::S_IDLE);
   assign rsp_valid = valid_ff;

   `ASC_ASSERT_RST(a_idle_clean, clock, reset, (phase_ff == asc_pkg::PH_IDLE) |-> !seen_ff && !dec_ff, "idle phase with message flags set")
   `ASC_ASSERT_RST(a_rnd_range, clock, reset, (state_ff == asc_pkg::S_RND) |-> (rnd_ff <= 4'd11), "round index out of range")
   `ASC_ASSERT_RST(a_emit_valid, clock, reset, emit |=> valid_ff, "result not raised after emit")
   `ASC_ASSERT_RST(a_keytail_order, clock, reset, (state_ff == asc_pkg::S_KEYTAIL) |-> ($past(state_ff) == asc_pkg::S_RND), "key tail without permutation")
endmodule
`default_nettype wire

FILE: hdl/ascon128a_aead_engine_unit.sv
// top level of the ascon-128a aead engine: register port, sequencer and datapath
`timescale 1ns / 1ps
`default_nettype none
// Ascon-128a AEAD engine, one round per cycle on a single round unit. A start item is
// accepted, loads the state, runs 12 rounds and adds the key; a full associated-data item
// is accepted, absorbed and runs 8 rounds; a text item likewise, plus any close of
// associated data; a finish item absorbs its last block, runs 12 rounds and forms the tag,
// plus any close. The result register frees the input side while a result waits; a text
// or finish item waits only for that register to empty. Key and tag length registers sit
// at byte addresses 0, 8 and 16 on the 64-bit register port.
module ascon128a_aead_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_decrypt,
   input  wire logic [63:0] req_data_high,
   input  wire logic [63:0] req_data_low,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic [63:0] req_check_tag_high,
   input  wire logic [63:0] req_check_tag_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_text_high,
   output logic [63:0]      rsp_text_low,
   output logic [4:0]       rsp_text_bytes,
   output logic [63:0]      rsp_tag_high,
   output logic [63:0]      rsp_tag_low,
   output logic             rsp_tag_ok,
   output logic             rsp_is_final,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   logic [63:0] key_high_ff, key_low_ff;
   logic [4:0]  tag_bytes_ff;
   asc_pkg::reg_index_type idx;
   asc_pkg::cmd_type cmd;

   assign idx = asc_pkg::reg_index_type'(paddr[4:3]);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         tag_bytes_ff <= 5'd16;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            asc_pkg::REG_KEY_HIGH:  key_high_ff <= pwdata;
            asc_pkg::REG_KEY_LOW:   key_low_ff <= pwdata;
            asc_pkg::REG_TAG_BYTES: tag_bytes_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         asc_pkg::REG_KEY_HIGH:  prdata = key_high_ff;
         asc_pkg::REG_KEY_LOW:   prdata = key_low_ff;
         asc_pkg::REG_TAG_BYTES: prdata = {59'd0, tag_bytes_ff};
         default: prdata = '0;
      endcase
   end

   asc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_decrypt,
      .req_byte_count, .rsp_valid, .rsp_stall, .cmd
   );

   asc_dp u_dp (
      .clock, .cmd,
      .key_high(key_high_ff), .key_low(key_low_ff), .tag_bytes(tag_bytes_ff),
      .req_data_high, .req_data_low, .req_byte_count,
      .req_check_tag_high, .req_check_tag_low,
      .rsp_text_high, .rsp_text_low, .rsp_text_bytes,
      .rsp_tag_high, .rsp_tag_low, .rsp_tag_ok, .rsp_is_final
   );
endmodule
`default_nettype wire

FILE: dv/aead_checker.sv
// checker for the ascon-128a engine: mirrors the sponge, predicts results and compares them
`timescale 1ns / 1ps
module aead_checker
   import asc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_decrypt,
   input  wire logic [63:0] req_data_high,
   input  wire logic [63:0] req_data_low,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic [63:0] req_check_tag_high,
   input  wire logic [63:0] req_check_tag_low,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_text_high,
   input  wire logic [63:0] rsp_text_low,
   input  wire logic [4:0]  rsp_text_bytes,
   input  wire logic [63:0] rsp_tag_high,
   input  wire logic [63:0] rsp_tag_low,
   input  wire logic        rsp_tag_ok,
   input  wire logic        rsp_is_final,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   input  wire logic        pready,
   output int               fail_count,
   output int               pending,
   output int               finals_seen,
   output int               tags_matched
);

   typedef struct {
      logic [63:0] text_high;
      logic [63:0] text_low;
      logic [4:0]  text_bytes;
      logic [63:0] tag_high;
      logic [63:0] tag_low;
      logic        tag_ok;
      logic        is_final;
   } aead_out_t;

   logic [63:0] sw [0:4];
   phase_type   msg_phase;
   bit          ad_absorbed;
   bit          decrypting;
   logic [63:0] key_hi, key_lo;
   logic [4:0]  tag_len;
   aead_out_t   awaited[$];
   int          mism = 0;
   int          n_final = 0;
   int          n_match = 0;

   assign fail_count   = mism;
   assign pending      = awaited.size();
   assign finals_seen  = n_final;
   assign tags_matched = n_match;

   function automatic logic [63:0] ror64(logic [63:0] v, int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   function automatic logic [63:0] lead_bytes_mask(int n);
      if (n <= 0) return 64'd0;
      if (n >= 8) return '1;
      return ~64'd0 << (64 - 8 * n);
   endfunction

   function automatic logic [63:0] pad_byte(int n);
      return 64'h80 << (56 - 8 * (n % 8));
   endfunction

   function automatic void permute_rounds(int rounds);
      logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
      logic [7:0] rc;
      for (int r = 12 - rounds; r < 12; r++) begin
         rc = 8'hf0 - 8'(r * 15);
         x0 = sw[0]; x1 = sw[1]; x2 = sw[2] ^ {56'd0, rc}; x3 = sw[3]; x4 = sw[4];
         x0 ^= x4; x4 ^= x3; x2 ^= x1;
         t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
         x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
         x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
         sw[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
         sw[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
         sw[2] = x2 ^ ror64(x2, 1) ^ ror64(x2, 6);
         sw[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
         sw[4] = x4 ^ ror64(x4, 7) ^ ror64(x4, 41);
      end
   endfunction

   function automatic void close_assoc(int n, logic [63:0] hi, logic [63:0] lo);
      if (ad_absorbed || n > 0) begin
         if (n >= 8) begin
            sw[0] ^= hi;
            sw[1] ^= (lo & lead_bytes_mask(n - 8)) ^ pad_byte(n - 8);
         end else begin
            sw[0] ^= (hi & lead_bytes_mask(n)) ^ pad_byte(n);
         end
         permute_rounds(8);
      end
      sw[4] ^= 64'd1;
      msg_phase = PH_TEXT;
   endfunction

   function automatic void clear_message();
      for (int i = 0; i < 5; i++) sw[i] = '0;
      msg_phase = PH_IDLE;
      ad_absorbed = 0;
      decrypting = 0;
   endfunction

   // advance the mirrored sponge by one item, queue its result if it makes one
   function automatic void absorb_item();
      action_type  act;
      logic [63:0] hi, lo, mk, cb, tmask_h, tmask_l, th, tl;
      int          n, t;
      aead_out_t   o;
      act = action_type'(req_action);
      hi = req_data_high;
      lo = req_data_low;
      n = req_byte_count;
      if (act == ACT_START) begin
         sw[0] = AEAD_IV; sw[1] = key_hi; sw[2] = key_lo; sw[3] = hi; sw[4] = lo;
         permute_rounds(12);
         sw[3] ^= key_hi;
         sw[4] ^= key_lo;
         msg_phase = PH_ASSOC;
         ad_absorbed = 0;
         decrypting = req_decrypt;
         return;
      end
      if (msg_phase == PH_IDLE) return;
      if (act == ACT_ASSOC) begin
         if (msg_phase != PH_ASSOC) return;
         if (n >= 16) begin
            sw[0] ^= hi; sw[1] ^= lo;
            permute_rounds(8);
            ad_absorbed = 1;
         end else begin
            close_assoc(n, hi, lo);
         end
         return;
      end
      if (msg_phase == PH_ASSOC) close_assoc(0, '0, '0);
      o.tag_high = '0; o.tag_low = '0; o.tag_ok = 0;
      if (act == ACT_TEXT) begin
         if (decrypting) begin
            o.text_high = sw[0] ^ hi; o.text_low = sw[1] ^ lo;
            sw[0] = hi; sw[1] = lo;
         end else begin
            sw[0] ^= hi; sw[1] ^= lo;
            o.text_high = sw[0]; o.text_low = sw[1];
         end
         permute_rounds(8);
         o.text_bytes = 5'd16;
         o.is_final = 0;
         awaited.push_back(o);
         return;
      end
      // finish: last partial block, then finalization with the current key
      if (n > 15) n = 15;
      t = tag_len;
      if (t == 0) t = 1;
      if (t > 16) t = 16;
      if (n >= 8) begin
         mk = lead_bytes_mask(n - 8);
         cb = lo & mk;
         if (decrypting) begin
            o.text_high = sw[0] ^ hi;
            o.text_low = (sw[1] ^ cb) & mk;
            sw[0] = hi;
            sw[1] = ((sw[1] & ~mk) | cb) ^ pad_byte(n - 8);
         end else begin
            sw[0] ^= hi;
            sw[1] ^= cb ^ pad_byte(n - 8);
            o.text_high = sw[0];
            o.text_low = sw[1] & mk;
         end
      end else begin
         mk = lead_bytes_mask(n);
         cb = hi & mk;
         if (decrypting) begin
            o.text_high = (sw[0] ^ cb) & mk;
            sw[0] = ((sw[0] & ~mk) | cb) ^ pad_byte(n);
         end else begin
            sw[0] ^= cb ^ pad_byte(n);
            o.text_high = sw[0] & mk;
         end
         o.text_low = '0;
      end
      o.text_bytes = 5'(n);
      sw[2] ^= key_hi;
      sw[3] ^= key_lo;
      permute_rounds(12);
      sw[3] ^= key_hi;
      sw[4] ^= key_lo;
      tmask_h = lead_bytes_mask(t);
      tmask_l = (t > 8) ? lead_bytes_mask(t - 8) : '0;
      th = sw[3] & tmask_h;
      tl = sw[4] & tmask_l;
      o.tag_high = th;
      o.tag_low = tl;
      o.tag_ok = decrypting && th == (req_check_tag_high & tmask_h)
                 && tl == (req_check_tag_low & tmask_l);
      o.is_final = 1;
      awaited.push_back(o);
      clear_message();
   endfunction

   function automatic void check_field(string nm, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mism++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         key_hi <= '0;
         key_lo <= '0;
         tag_len <= 5'd16;
         awaited.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               mism++;
               $display("%0t: unexpected result item, expected none, actual text %h_%h tag %h_%h",
                        $time, rsp_text_high, rsp_text_low, rsp_tag_high, rsp_tag_low);
            end else begin
               aead_out_t w;
               w = awaited.pop_front();
               check_field("text_high", w.text_high, rsp_text_high);
               check_field("text_low", w.text_low, rsp_text_low);
               check_field("text_bytes", 64'(w.text_bytes), 64'(rsp_text_bytes));
               check_field("tag_high", w.tag_high, rsp_tag_high);
               check_field("tag_low", w.tag_low, rsp_tag_low);
               check_field("tag_ok", 64'(w.tag_ok), 64'(rsp_tag_ok));
               check_field("is_final", 64'(w.is_final), 64'(rsp_is_final));
               if (w.is_final) n_final++;
               if (w.tag_ok) n_match++;
            end
         end
         if (req_valid && !req_stall) absorb_item();
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:3]))
               REG_KEY_HIGH:  key_hi <= pwdata;
               REG_KEY_LOW:   key_lo <= pwdata;
               REG_TAG_BYTES: tag_len <= pwdata[4:0];
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: dv/testbench.sv
// top of the ascon-128a engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
   import asc_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_START;
   logic        req_decrypt = 0;
   logic [63:0] req_data_high = '0;
   logic [63:0] req_data_low = '0;
   logic [4:0]  req_byte_count = '0;
   logic [63:0] req_check_tag_high = '0;
   logic [63:0] req_check_tag_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_text_high, rsp_text_low, rsp_tag_high, rsp_tag_low;
   logic [4:0]  rsp_text_bytes;
   logic        rsp_tag_ok, rsp_is_final;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   int fail_count, pending, finals_seen, tags_matched;
   int items_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_rsp = 0;
   int quiet_cycles = 0;

   typedef struct {
      logic [63:0] text_high, text_low, tag_high, tag_low;
   } seen_out_t;
   seen_out_t out_log[$];

   always #4 clock = ~clock;

   ascon128a_aead_engine_unit dut (.*);

   aead_checker checker_i (.*);

   always @(negedge clock) rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         out_log.push_back('{rsp_text_high, rsp_text_low, rsp_tag_high, rsp_tag_low});
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(action_type act, logic dec, logic [63:0] hi, logic [63:0] lo,
                            logic [4:0] cnt, logic [63:0] ch, logic [63:0] cl);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_decrypt <= dec;
      req_data_high <= hi;
      req_data_low <= lo;
      req_byte_count <= cnt;
      req_check_tag_high <= ch;
      req_check_tag_low <= cl;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_simple(action_type act, logic dec, logic [4:0] cnt);
      send_item(act, dec, rand64(), rand64(), cnt, rand64(), rand64());
   endtask

   // drop valid, wait for every result and let any result-less work finish
   task automatic settle();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // setup and access cycles, then psel and penable drop before the next transfer
   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(negedge clock);
   endtask

   task automatic set_config(logic [63:0] khi, logic [63:0] klo, logic [4:0] tlen);
      settle();
      csr_write(REG_KEY_HIGH, khi);
      csr_write(REG_KEY_LOW, klo);
      csr_write(REG_TAG_BYTES, 64'(tlen));
   endtask

   task automatic random_message();
      logic dec;
      int   n_ad, n_txt;
      dec = $urandom_range(1);
      n_ad = $urandom_range(3);
      n_txt = $urandom_range(4);
      send_simple(ACT_START, dec, 5'($urandom_range(31)));
      repeat (n_ad) send_simple(ACT_ASSOC, $urandom_range(1), 5'($urandom_range(16, 31)));
      if ($urandom_range(1)) send_simple(ACT_ASSOC, $urandom_range(1), 5'($urandom_range(15)));
      repeat (n_txt) send_simple(ACT_TEXT, $urandom_range(1), 5'($urandom_range(31)));
      send_simple(ACT_FINISH, $urandom_range(1), 5'($urandom_range(31)));
   endtask

   // encrypt a message, then decrypt its ciphertext with the returned tag
   task automatic round_trip();
      logic [63:0] nonce_h, nonce_l, ad_h[$], ad_l[$], last_h, last_l;
      logic [4:0]  ad_cnt[$], fin_cnt;
      int          n_txt;
      seen_out_t   got[$];
      settle();
      nonce_h = rand64();
      nonce_l = rand64();
      for (int i = $urandom_range(3); i > 0; i--) begin
         ad_h.push_back(rand64());
         ad_l.push_back(rand64());
         ad_cnt.push_back(5'(i == 1 && $urandom_range(1) ? $urandom_range(15) : 16));
      end
      n_txt = $urandom_range(3);
      fin_cnt = 5'($urandom_range(15));
      out_log.delete();
      for (int pass = 0; pass < 2; pass++) begin
         send_item(ACT_START, pass[0], nonce_h, nonce_l, 5'd16, rand64(), rand64());
         foreach (ad_h[i]) send_item(ACT_ASSOC, 0, ad_h[i], ad_l[i], ad_cnt[i], '0, '0);
         for (int i = 0; i < n_txt; i++) begin
            if (pass == 0) send_simple(ACT_TEXT, 0, 5'd16);
            else send_item(ACT_TEXT, 0, got[i].text_high, got[i].text_low, 5'd16, '0, '0);
         end
         if (pass == 0) begin
            send_simple(ACT_FINISH, 0, fin_cnt);
            settle();
            got = out_log;
         end else begin
            last_h = got[n_txt].text_high;
            last_l = got[n_txt].text_low;
            send_item(ACT_FINISH, 0, last_h, last_l, fin_cnt, got[n_txt].tag_high,
                      got[n_txt].tag_low);
         end
      end
   endtask

   initial begin
      int phase_idle[4] = '{0, 86, 0, 34};
      int phase_stall[4] = '{0, 0, 86, 34};
      int target;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: items while idle are ignored
      send_simple(ACT_TEXT, 0, 5'd16);
      send_simple(ACT_FINISH, 1, 5'd3);
      send_simple(ACT_ASSOC, 0, 5'd16);
      // full block with a large count, short close, late associated data, odd text count
      send_item(ACT_START, 0, '1, '1, 5'd31, '1, '1);
      send_item(ACT_ASSOC, 1, '1, '0, 5'd20, '0, '0);
      send_item(ACT_ASSOC, 0, '0, '1, 5'd5, '0, '0);
      send_simple(ACT_ASSOC, 0, 5'd16);
      send_item(ACT_TEXT, 0, '0, '0, 5'd3, '0, '0);
      send_item(ACT_FINISH, 0, '1, '1, 5'd31, '1, '1);
      // a start abandons the running message; text closes empty associated data
      send_simple(ACT_START, 1, 5'd0);
      send_item(ACT_START, 0, '0, '0, 5'd0, '0, '0);
      send_item(ACT_TEXT, 1, '1, '0, 5'd0, '0, '0);
      send_item(ACT_FINISH, 0, '0, '0, 5'd0, '0, '0);
      // explicitly empty associated data, decrypt with a wrong tag
      send_simple(ACT_START, 1, 5'd16);
      send_simple(ACT_ASSOC, 0, 5'd0);
      send_simple(ACT_FINISH, 0, 5'd8);
      // a full block then a text item closes with an empty padded block
      send_simple(ACT_START, 0, 5'd16);
      send_simple(ACT_ASSOC, 0, 5'd16);
      send_simple(ACT_TEXT, 0, 5'd16);
      send_simple(ACT_FINISH, 0, 5'd15);
      // key changed between start and finish
      send_simple(ACT_START, 0, 5'd16);
      send_simple(ACT_ASSOC, 0, 5'd9);
      settle();
      csr_write(REG_KEY_HIGH, rand64());
      send_simple(ACT_FINISH, 0, 5'd7);
      // tag lengths outside the usual range
      set_config('1, '1, 5'd0);
      round_trip();
      set_config('0, '1, 5'd17);
      random_message();
      set_config(rand64(), rand64(), 5'd1);
      round_trip();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_config(rand64(), rand64(), 5'd16);
            1: set_config('1, '1, 5'd31);
            2: set_config('0, '0, 5'd8);
            default: set_config(rand64(), rand64(), 5'($urandom_range(1, 16)));
         endcase
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         target = items_sent + 385;
         if (p == 0) begin
            // long receiver hold-off while the sender keeps offering text items
            fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(negedge clock);
                  hold_rsp = 0;
               end
            join_none
            send_simple(ACT_START, 0, 5'd16);
            repeat (12) send_simple(ACT_TEXT, 0, 5'd16);
            send_simple(ACT_FINISH, 0, 5'd4);
         end
         while (items_sent < target) begin
            case ($urandom_range(9))
               0: send_simple(action_type'($urandom_range(3)), $urandom_range(1),
                              5'($urandom_range(31)));
               1: round_trip();
               default: random_message();
            endcase
         end
      end

      idle_pct = 0;
      stall_pct = 0;
      settle();
      $display("covered %0d items over four idle/stall mixes and seven key/tag settings,",
               items_sent);
      $display("%0d messages finished, %0d decryptions with a matching tag",
               finals_seen, tags_matched);
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
